/* design/hsm_pkg.sv */
// Shared types, codes and defaults for the two-wire humidity sensor bus master.
package hsm_pkg;

  // Command codes carried by the op field of an input transfer.
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_MEAS_TEMP = 3'd1;
  localparam logic [2:0] OP_MEAS_HUM  = 3'd2;
  localparam logic [2:0] OP_SOFT_RST  = 3'd3;
  localparam logic [2:0] OP_CONN_RST  = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CMD_TEMP  = 2'd0;
  localparam logic [1:0] CFG_CMD_HUM   = 2'd1;
  localparam logic [1:0] CFG_CMD_SRST  = 2'd2;
  localparam logic [1:0] CFG_RDY_TMO   = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register reset values.
  localparam logic [7:0]  CMD_TEMP_RST = 8'd3;
  localparam logic [7:0]  CMD_HUM_RST  = 8'd5;
  localparam logic [7:0]  CMD_SRST_RST = 8'd30;
  localparam logic [15:0] RDY_TMO_RST  = 16'hFFFF;

  // Default number of clock pulses in a connection reset.
  localparam int RESET_CLOCKS_DEF = 9;

  typedef struct packed {
    logic [2:0] op;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic        scl;
    logic        sda_release;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  error_count;
    logic [15:0] value;
    logic [7:0]  checksum;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  cmd_temperature;
    logic [7:0]  cmd_humidity;
    logic [7:0]  cmd_soft_reset;
    logic [15:0] ready_timeout;
  } cfg_t;

endpackage

/* design/humidity_sensor_two_wire_master.sv */
// Top level of the two-wire humidity and temperature sensor bus master.
//
// Each input transfer is one bus timing tick: it carries the sampled data
// line and an optional command (measure temperature, measure humidity, soft
// reset, connection reset), and produces exactly one result transfer with
// the clock and data line levels to drive until the next tick, plus busy,
// done and, on the finishing tick, the error count, the raw 16-bit value and
// the checksum byte. A command is taken only while the sequencer is idle;
// on any other tick it is ignored. The design accepts one tick per clock
// cycle: the sequencer state advances in the cycle a tick is accepted and
// the result lands in a single output register, which presents it in the
// next cycle; the throughput is one tick per cycle, limited only by the
// output register being taken. The configuration registers (command
// bytes and data-ready timeout) are written through a plain write port and
// should only be changed while no command sequence is in progress.
module humidity_sensor_two_wire_master
  import hsm_pkg::*;
#(
  parameter int RESET_CLOCKS = RESET_CLOCKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg_r;
  out_item_t res;
  out_item_t out_r;
  logic      out_valid_r;
  logic      step;

  // A new tick is taken whenever the output register is empty or its
  // current result is being transferred in this cycle.
  assign in_ready  = !out_valid_r || out_ready;
  assign step      = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cmd_temperature <= CMD_TEMP_RST;
      cfg_r.cmd_humidity    <= CMD_HUM_RST;
      cfg_r.cmd_soft_reset  <= CMD_SRST_RST;
      cfg_r.ready_timeout   <= RDY_TMO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CMD_TEMP: cfg_r.cmd_temperature <= cfg_data[7:0];
        CFG_CMD_HUM:  cfg_r.cmd_humidity    <= cfg_data[7:0];
        CFG_CMD_SRST: cfg_r.cmd_soft_reset  <= cfg_data[7:0];
        CFG_RDY_TMO:  cfg_r.ready_timeout   <= cfg_data;
        default: ;
      endcase
    end
  end

  hsm_seq #(
    .RESET_CLOCKS(RESET_CLOCKS)
  ) u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .step (step),
    .item (in_data),
    .cfg  (cfg_r),
    .res  (res)
  );

  // Output register: holds the result until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted tick produced no result");
`endif

endmodule

/* design/hsm_seq.sv */
// Bus sequencer: one bus step per accepted tick, result computed in the same cycle.
module hsm_seq
  import hsm_pkg::*;
#(
  parameter int RESET_CLOCKS = RESET_CLOCKS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t res
);

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_CR_HIGH = 5'd1,
    PH_CR_LOW  = 5'd2,
    PH_START   = 5'd3,
    PH_WR_DATA = 5'd4,
    PH_WR_HIGH = 5'd5,
    PH_WR_LOW  = 5'd6,
    PH_WR_REL  = 5'd7,
    PH_WR_ACKH = 5'd8,
    PH_WR_ACKL = 5'd9,
    PH_WAIT    = 5'd10,
    PH_RD_REL  = 5'd11,
    PH_RD_HIGH = 5'd12,
    PH_RD_LOW  = 5'd13,
    PH_RD_ACKD = 5'd14,
    PH_RD_ACKH = 5'd15,
    PH_RD_ACKL = 5'd16
  } phase_t;

  localparam logic [3:0] RstClocks = 4'(RESET_CLOCKS);

  phase_t      phase_r, phase_nxt;
  logic [2:0]  cmd_r, cmd_nxt;
  logic [3:0]  bit_cnt_r, bit_cnt_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [1:0]  byte_idx_r, byte_idx_nxt;
  logic [15:0] wait_cnt_r, wait_cnt_nxt;
  logic [15:0] value_r, value_nxt;
  logic [7:0]  csum_r, csum_nxt;
  logic [1:0]  err_r, err_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        busy, done;
  logic [3:0]  bit_inc;
  logic [15:0] wait_inc;

  assign bit_inc  = bit_cnt_r + 4'd1;
  assign wait_inc = wait_cnt_r + 16'd1;

  always_comb begin
    phase_nxt    = phase_r;
    cmd_nxt      = cmd_r;
    bit_cnt_nxt  = bit_cnt_r;
    shift_nxt    = shift_r;
    byte_idx_nxt = byte_idx_r;
    wait_cnt_nxt = wait_cnt_r;
    value_nxt    = value_r;
    csum_nxt     = csum_r;
    err_nxt      = err_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    busy         = 1'b1;
    done         = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (item.op == OP_MEAS_TEMP || item.op == OP_MEAS_HUM ||
            item.op == OP_SOFT_RST || item.op == OP_CONN_RST) begin
          cmd_nxt      = item.op;
          bit_cnt_nxt  = '0;
          shift_nxt    = '0;
          byte_idx_nxt = '0;
          wait_cnt_nxt = '0;
          value_nxt    = '0;
          csum_nxt     = '0;
          err_nxt      = '0;
          scl_nxt      = 1'b0;
          sda_nxt      = 1'b1;
          phase_nxt    = (item.op == OP_SOFT_RST || item.op == OP_CONN_RST) ?
                         PH_CR_HIGH : PH_START;
        end else begin
          busy = 1'b0;
        end
      end
      PH_CR_HIGH: begin
        scl_nxt   = 1'b1;
        phase_nxt = PH_CR_LOW;
      end
      PH_CR_LOW: begin
        scl_nxt = 1'b0;
        if (bit_inc >= RstClocks) begin
          bit_cnt_nxt = '0;
          phase_nxt   = PH_START;
        end else begin
          bit_cnt_nxt = bit_inc;
          phase_nxt   = PH_CR_HIGH;
        end
      end
      PH_START: begin
        case (bit_cnt_r)
          4'd0:    scl_nxt = 1'b1;
          4'd1:    sda_nxt = 1'b0;
          4'd2:    scl_nxt = 1'b0;
          4'd3:    scl_nxt = 1'b1;
          4'd4:    sda_nxt = 1'b1;
          default: scl_nxt = 1'b0;
        endcase
        if (bit_cnt_r >= 4'd5) begin
          bit_cnt_nxt = '0;
          if (cmd_r == OP_CONN_RST) begin
            done = 1'b1;
          end else begin
            if (cmd_r == OP_MEAS_TEMP) shift_nxt = cfg.cmd_temperature;
            else if (cmd_r == OP_MEAS_HUM) shift_nxt = cfg.cmd_humidity;
            else shift_nxt = cfg.cmd_soft_reset;
            phase_nxt = PH_WR_DATA;
          end
        end else begin
          bit_cnt_nxt = bit_inc;
        end
      end
      PH_WR_DATA: begin
        sda_nxt   = shift_r[7];
        phase_nxt = PH_WR_HIGH;
      end
      PH_WR_HIGH: begin
        scl_nxt   = 1'b1;
        phase_nxt = PH_WR_LOW;
      end
      PH_WR_LOW: begin
        scl_nxt   = 1'b0;
        shift_nxt = {shift_r[6:0], 1'b0};
        if (bit_inc >= 4'd8) begin
          bit_cnt_nxt = '0;
          phase_nxt   = PH_WR_REL;
        end else begin
          bit_cnt_nxt = bit_inc;
          phase_nxt   = PH_WR_DATA;
        end
      end
      PH_WR_REL: begin
        sda_nxt   = 1'b1;
        phase_nxt = PH_WR_ACKH;
      end
      PH_WR_ACKH: begin
        scl_nxt = 1'b1;
        // A released data line during the acknowledge clock is a missing ack.
        if (item.sda_in && err_r != 2'd3) err_nxt = err_r + 2'd1;
        phase_nxt = PH_WR_ACKL;
      end
      PH_WR_ACKL: begin
        scl_nxt = 1'b0;
        if (cmd_r == OP_SOFT_RST) begin
          done = 1'b1;
        end else begin
          wait_cnt_nxt = '0;
          phase_nxt    = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (!item.sda_in) begin
          byte_idx_nxt = '0;
          phase_nxt    = PH_RD_REL;
        end else begin
          wait_cnt_nxt = wait_inc;
          if (wait_inc >= cfg.ready_timeout) begin
            if (err_r != 2'd3) err_nxt = err_r + 2'd1;
            byte_idx_nxt = '0;
            phase_nxt    = PH_RD_REL;
          end
        end
      end
      PH_RD_REL: begin
        sda_nxt     = 1'b1;
        shift_nxt   = '0;
        bit_cnt_nxt = '0;
        phase_nxt   = PH_RD_HIGH;
      end
      PH_RD_HIGH: begin
        scl_nxt   = 1'b1;
        shift_nxt = {shift_r[6:0], item.sda_in};
        phase_nxt = PH_RD_LOW;
      end
      PH_RD_LOW: begin
        scl_nxt     = 1'b0;
        bit_cnt_nxt = bit_inc;
        phase_nxt   = (bit_inc >= 4'd8) ? PH_RD_ACKD : PH_RD_HIGH;
      end
      PH_RD_ACKD: begin
        if (byte_idx_r == 2'd0) begin
          value_nxt = {shift_r, value_r[7:0]};
          sda_nxt   = 1'b0;
        end else if (byte_idx_r == 2'd1) begin
          value_nxt = {value_r[15:8], shift_r};
          sda_nxt   = 1'b0;
        end else begin
          csum_nxt = shift_r;
          sda_nxt  = 1'b1;
        end
        phase_nxt = PH_RD_ACKH;
      end
      PH_RD_ACKH: begin
        scl_nxt   = 1'b1;
        phase_nxt = PH_RD_ACKL;
      end
      PH_RD_ACKL: begin
        scl_nxt = 1'b0;
        if (byte_idx_r >= 2'd2) begin
          done = 1'b1;
        end else begin
          byte_idx_nxt = byte_idx_r + 2'd1;
          phase_nxt    = PH_RD_REL;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        busy      = 1'b0;
      end
    endcase
    if (done) phase_nxt = PH_IDLE;
  end

  always_comb begin
    res.scl         = scl_nxt;
    res.sda_release = sda_nxt;
    res.busy_res    = busy;
    res.done_res    = done;
    res.error_count = done ? err_nxt : 2'd0;
    res.value       = done ? value_nxt : 16'd0;
    res.checksum    = done ? csum_nxt : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      cmd_r      <= '0;
      bit_cnt_r  <= '0;
      shift_r    <= '0;
      byte_idx_r <= '0;
      wait_cnt_r <= '0;
      value_r    <= '0;
      csum_r     <= '0;
      err_r      <= '0;
      scl_r      <= 1'b0;
      sda_r      <= 1'b1;
    end else if (step) begin
      phase_r    <= phase_nxt;
      cmd_r      <= cmd_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      shift_r    <= shift_nxt;
      byte_idx_r <= byte_idx_nxt;
      wait_cnt_r <= wait_cnt_nxt;
      value_r    <= value_nxt;
      csum_r     <= csum_nxt;
      err_r      <= err_nxt;
      scl_r      <= scl_nxt;
      sda_r      <= sda_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.done_res |=> phase_r == PH_IDLE)
    else $error("sequencer did not return to idle after finishing");

  a_busy_when_active: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r != PH_IDLE |-> res.busy_res)
    else $error("active step reported as not busy");

  a_write_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_WR_DATA || phase_r == PH_WR_HIGH || phase_r == PH_WR_LOW)
      |-> bit_cnt_r < 4'd8)
    else $error("write bit counter out of range");
`endif

endmodule
